// ----- rtl/vssd_pkg.sv -----
`timescale 1ns / 1ps

package vssd_pkg;

    // Field widths fixed by the sample and result formats
    localparam int LEVEL_W = 16;
    localparam int TIME_W  = 32;
    localparam int RUN_W   = 8;
    localparam int POST_W  = 16;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 3;

    // Default sizing
    localparam int DEF_AVG_DEPTH            = 3;
    localparam int DEF_SAG_START_WINDOWS    = 3;
    localparam int DEF_SAG_END_WINDOWS      = 3;
    localparam int DEF_SWELL_START_WINDOWS  = 3;
    localparam int DEF_SWELL_END_WINDOWS    = 3;
    localparam int DEF_CRITICAL_END_WINDOWS = 3;

    // Register reset values
    localparam logic [CFG_W-1:0] RST_SAG_START    = 16'd20700;
    localparam logic [CFG_W-1:0] RST_SAG_END      = 16'd21100;
    localparam logic [CFG_W-1:0] RST_SWELL_START  = 16'd25300;
    localparam logic [CFG_W-1:0] RST_SWELL_END    = 16'd24900;
    localparam logic [CFG_W-1:0] RST_CRIT_LOW     = 16'd11500;
    localparam logic [CFG_W-1:0] RST_CRIT_HIGH    = 16'd27600;
    localparam logic [CFG_W-1:0] RST_POST_POINTS  = 16'd10;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SAG_START   = 3'd0,
        REG_SAG_END     = 3'd1,
        REG_SWELL_START = 3'd2,
        REG_SWELL_END   = 3'd3,
        REG_CRIT_LOW    = 3'd4,
        REG_CRIT_HIGH   = 3'd5,
        REG_POST_POINTS = 3'd6
    } cfg_index_t;

    // Event kinds
    typedef enum logic [1:0] {
        KIND_SAG      = 2'd0,
        KIND_SWELL    = 2'd1,
        KIND_CRITICAL = 2'd2
    } kind_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic               no_signal;
        logic [TIME_W-1:0]  time_ms;
    } sample_t;

    typedef struct packed {
        logic               event_active;
        logic [1:0]         event_kind;
        logic               event_started;
        logic               event_done;
        logic [TIME_W-1:0]  start_time;
        logic [TIME_W-1:0]  end_time;
        logic [LEVEL_W-1:0] min_level;
        logic [LEVEL_W-1:0] max_level;
    } result_t;

endpackage

// ----- rtl/vssd_stream_if.sv -----
`timescale 1ns / 1ps

// valid/ready channel carrying one request payload
interface vssd_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/voltage_sag_swell_event_detector.sv -----
`timescale 1ns / 1ps

// Voltage sag / swell / critical event detector.
// sample channel: one RMS level (0.01 V), a no-signal flag and a ms timestamp
//   per request. result channel: one result request for every sample.
// cfg port: cfg_we writes cfg_data[15:0] to register cfg_index (0..6) at the
//   clock edge; other indexes are ignored. Write only while the block is idle.
// Throughput: one sample per cycle while the result buffer is not full. The whole update (history mean compares,
//   run counters, event tracking) is a single registered pass from the
//   history/state registers into a two-entry result buffer.
// The result is registered into the buffer when its sample is accepted and is shown once earlier results are taken.
// Stall: the result buffer holds two results; sample.ready stays high while a
//   result waits and drops only when both entries are full.
// Reset: registers return to their defaults, history and all event state
//   clear, the result buffer empties.
module voltage_sag_swell_event_detector #(
    parameter int AVG_DEPTH            = vssd_pkg::DEF_AVG_DEPTH,
    parameter int SAG_START_WINDOWS    = vssd_pkg::DEF_SAG_START_WINDOWS,
    parameter int SAG_END_WINDOWS      = vssd_pkg::DEF_SAG_END_WINDOWS,
    parameter int SWELL_START_WINDOWS  = vssd_pkg::DEF_SWELL_START_WINDOWS,
    parameter int SWELL_END_WINDOWS    = vssd_pkg::DEF_SWELL_END_WINDOWS,
    parameter int CRITICAL_END_WINDOWS = vssd_pkg::DEF_CRITICAL_END_WINDOWS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [vssd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [vssd_pkg::CFG_W-1:0]     cfg_data,
    vssd_stream_if.sink                    sample,
    vssd_stream_if.source                  result
);

    localparam int CNT_W = $clog2(AVG_DEPTH + 1);
    localparam int SUM_W = vssd_pkg::LEVEL_W + CNT_W;
    localparam int LW    = vssd_pkg::LEVEL_W;
    localparam int TW    = vssd_pkg::TIME_W;
    localparam int RW    = vssd_pkg::RUN_W;
    localparam int PW    = vssd_pkg::POST_W;

    localparam logic [RW-1:0] SAG_START_N  = RW'(SAG_START_WINDOWS);
    localparam logic [RW-1:0] SAG_END_N    = RW'(SAG_END_WINDOWS);
    localparam logic [RW-1:0] SWELL_START_N = RW'(SWELL_START_WINDOWS);
    localparam logic [RW-1:0] SWELL_END_N  = RW'(SWELL_END_WINDOWS);
    localparam logic [RW-1:0] CRIT_END_N   = RW'(CRITICAL_END_WINDOWS);
    localparam logic [RW-1:0] RUN_MAX      = {RW{1'b1}};
    localparam logic [PW-1:0] POST_MAX     = {PW{1'b1}};

    // count * threshold, exact
    function automatic logic [SUM_W-1:0] scale(input logic [CNT_W-1:0] cnt,
                                               input logic [LW-1:0] thr);
        return SUM_W'(cnt) * SUM_W'(thr);
    endfunction

    function automatic logic [RW-1:0] bump8(input logic [RW-1:0] c);
        return (c != RUN_MAX) ? c + RW'(1) : RUN_MAX;
    endfunction

    // Configuration registers
    logic [LW-1:0] sag_start_reg, sag_end_reg, swell_start_reg, swell_end_reg;
    logic [LW-1:0] crit_low_reg, crit_high_reg;
    logic [PW-1:0] post_points_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sag_start_reg   <= vssd_pkg::RST_SAG_START;
            sag_end_reg     <= vssd_pkg::RST_SAG_END;
            swell_start_reg <= vssd_pkg::RST_SWELL_START;
            swell_end_reg   <= vssd_pkg::RST_SWELL_END;
            crit_low_reg    <= vssd_pkg::RST_CRIT_LOW;
            crit_high_reg   <= vssd_pkg::RST_CRIT_HIGH;
            post_points_reg <= vssd_pkg::RST_POST_POINTS;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                vssd_pkg::REG_SAG_START:   sag_start_reg   <= cfg_data;
                vssd_pkg::REG_SAG_END:     sag_end_reg     <= cfg_data;
                vssd_pkg::REG_SWELL_START: swell_start_reg <= cfg_data;
                vssd_pkg::REG_SWELL_END:   swell_end_reg   <= cfg_data;
                vssd_pkg::REG_CRIT_LOW:    crit_low_reg    <= cfg_data;
                vssd_pkg::REG_CRIT_HIGH:   crit_high_reg   <= cfg_data;
                vssd_pkg::REG_POST_POINTS: post_points_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // State
    logic [LW-1:0]   hist_lvl_reg    [AVG_DEPTH];
    logic            hist_inval_reg  [AVG_DEPTH];
    logic            hist_fill_reg   [AVG_DEPTH];
    logic [LW-1:0]   hist_lvl_next   [AVG_DEPTH];
    logic            hist_inval_next [AVG_DEPTH];
    logic            hist_fill_next  [AVG_DEPTH];

    logic            active_flag_reg, active_flag_next;
    logic            post_flag_reg, post_flag_next;
    vssd_pkg::kind_t active_kind_reg, active_kind_next;
    logic [RW-1:0]   sag_run_reg, sag_run_next;
    logic [RW-1:0]   swell_run_reg, swell_run_next;
    logic [RW-1:0]   end_run_reg, end_run_next;
    logic [PW-1:0]   post_run_reg, post_run_next;
    logic [TW-1:0]   ev_start_reg, ev_start_next;
    logic [TW-1:0]   ev_end_reg, ev_end_next;
    logic [LW-1:0]   ev_min_reg, ev_min_next;
    logic [LW-1:0]   ev_max_reg, ev_max_next;

    vssd_pkg::sample_t s;
    vssd_pkg::result_t res_next;
    logic              push, pop;

    assign s    = sample.payload;
    assign push = sample.valid && sample.ready;
    assign pop  = result.valid && result.ready;

    // History after shifting in the current sample
    always_comb
    begin
        hist_lvl_next[0]   = s.level;
        hist_inval_next[0] = s.no_signal;
        hist_fill_next[0]  = 1'b1;
        for (int i = 1; i < AVG_DEPTH; i++)
        begin
            hist_lvl_next[i]   = hist_lvl_reg[i-1];
            hist_inval_next[i] = hist_inval_reg[i-1];
            hist_fill_next[i]  = hist_fill_reg[i-1];
        end
    end

    // Sum and count of valid history entries
    logic [SUM_W-1:0] det_sum;
    logic [CNT_W-1:0] det_cnt;

    always_comb
    begin
        det_sum = '0;
        det_cnt = '0;
        for (int i = 0; i < AVG_DEPTH; i++)
        begin
            if (hist_fill_next[i] && !hist_inval_next[i])
            begin
                det_sum = det_sum + SUM_W'(hist_lvl_next[i]);
                det_cnt = det_cnt + CNT_W'(1);
            end
        end
    end

    // Exact threshold compares
    logic below_sag_start, above_sag_end, above_swell_start, below_swell_end;
    logic below_crit_low, above_crit_low, below_crit_high, above_crit_high;

    always_comb
    begin
        below_sag_start   = det_sum < scale(det_cnt, sag_start_reg);
        above_sag_end     = det_sum > scale(det_cnt, sag_end_reg);
        above_swell_start = det_sum > scale(det_cnt, swell_start_reg);
        below_swell_end   = det_sum < scale(det_cnt, swell_end_reg);
        below_crit_low    = det_sum < scale(det_cnt, crit_low_reg);
        above_crit_low    = det_sum > scale(det_cnt, crit_low_reg);
        below_crit_high   = det_sum < scale(det_cnt, crit_high_reg);
        above_crit_high   = det_sum > scale(det_cnt, crit_high_reg);
    end

    // Event tracking for one sample
    logic            started, done;
    logic            cond, met;
    logic [RW-1:0]   need;
    logic [RW-1:0]   sag_bump, swell_bump;
    logic [PW-1:0]   post_base;

    always_comb
    begin
        active_flag_next = active_flag_reg;
        post_flag_next   = post_flag_reg;
        active_kind_next = active_kind_reg;
        sag_run_next     = sag_run_reg;
        swell_run_next   = swell_run_reg;
        end_run_next     = end_run_reg;
        post_run_next    = post_run_reg;
        ev_start_next    = ev_start_reg;
        ev_end_next      = ev_end_reg;
        ev_min_next      = ev_min_reg;
        ev_max_next      = ev_max_reg;
        started          = 1'b0;
        done             = 1'b0;
        cond             = 1'b0;
        met              = 1'b0;
        need             = CRIT_END_N;
        post_base        = post_run_reg;
        sag_bump         = below_sag_start ? bump8(sag_run_reg) : '0;
        swell_bump       = above_swell_start ? bump8(swell_run_reg) : '0;

        unique case (active_kind_reg)
            vssd_pkg::KIND_SAG:
            begin
                cond = above_sag_end;
                need = SAG_END_N;
            end
            vssd_pkg::KIND_SWELL:
            begin
                cond = below_swell_end;
                need = SWELL_END_N;
            end
            default:
            begin
                cond = above_crit_low && below_crit_high;
                need = CRIT_END_N;
            end
        endcase

        priority if (s.no_signal)
        begin
            // no signal drops the event and all runs
            active_flag_next = 1'b0;
            post_flag_next   = 1'b0;
            sag_run_next     = '0;
            swell_run_next   = '0;
            end_run_next     = '0;
            post_run_next    = '0;
        end
        else if (active_flag_reg)
        begin
            if (s.level < ev_min_reg) ev_min_next = s.level;
            if (s.level > ev_max_reg) ev_max_next = s.level;
            end_run_next = cond ? bump8(end_run_reg) : '0;
            met          = end_run_next >= need;
            if (met && !post_flag_reg)
            begin
                ev_end_next = s.time_ms;
                post_base   = '0;
            end
            post_flag_next = post_flag_reg || met;
            if (post_flag_next)
            begin
                post_run_next = (post_base != POST_MAX) ? post_base + PW'(1) : POST_MAX;
                if (post_run_next >= post_points_reg)
                begin
                    done             = 1'b1;
                    active_flag_next = 1'b0;
                    post_flag_next   = 1'b0;
                end
            end
        end
        else if (below_crit_low || above_crit_high)
        begin
            started          = 1'b1;
            active_kind_next = vssd_pkg::KIND_CRITICAL;
        end
        else
        begin
            sag_run_next   = sag_bump;
            swell_run_next = swell_bump;
            if (sag_bump >= SAG_START_N)
            begin
                started          = 1'b1;
                active_kind_next = vssd_pkg::KIND_SAG;
                sag_run_next     = '0;
            end
            else if (swell_bump >= SWELL_START_N)
            begin
                started          = 1'b1;
                active_kind_next = vssd_pkg::KIND_SWELL;
                swell_run_next   = '0;
            end
        end

        // common event start
        if (started)
        begin
            active_flag_next = 1'b1;
            post_flag_next   = 1'b0;
            end_run_next     = '0;
            post_run_next    = '0;
            ev_start_next    = s.time_ms;
            ev_end_next      = '0;
            ev_min_next      = s.level;
            ev_max_next      = s.level;
        end
    end

    // Result for this sample
    always_comb
    begin
        res_next.event_active  = active_flag_next;
        res_next.event_kind    = active_flag_next ? active_kind_next
                               : (done ? active_kind_reg : 2'd0);
        res_next.event_started = started;
        res_next.event_done    = done;
        res_next.start_time    = done ? ev_start_next : '0;
        res_next.end_time      = done ? ev_end_next : '0;
        res_next.min_level     = done ? ev_min_next : '0;
        res_next.max_level     = done ? ev_max_next : '0;
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < AVG_DEPTH; i++)
            begin
                hist_lvl_reg[i]   <= '0;
                hist_inval_reg[i] <= 1'b0;
                hist_fill_reg[i]  <= 1'b0;
            end
            active_flag_reg <= 1'b0;
            post_flag_reg   <= 1'b0;
            active_kind_reg <= vssd_pkg::KIND_SAG;
            sag_run_reg     <= '0;
            swell_run_reg   <= '0;
            end_run_reg     <= '0;
            post_run_reg    <= '0;
            ev_start_reg    <= '0;
            ev_end_reg      <= '0;
            ev_min_reg      <= '0;
            ev_max_reg      <= '0;
        end
        else if (push)
        begin
            for (int i = 0; i < AVG_DEPTH; i++)
            begin
                hist_lvl_reg[i]   <= hist_lvl_next[i];
                hist_inval_reg[i] <= hist_inval_next[i];
                hist_fill_reg[i]  <= hist_fill_next[i];
            end
            active_flag_reg <= active_flag_next;
            post_flag_reg   <= post_flag_next;
            active_kind_reg <= active_kind_next;
            sag_run_reg     <= sag_run_next;
            swell_run_reg   <= swell_run_next;
            end_run_reg     <= end_run_next;
            post_run_reg    <= post_run_next;
            ev_start_reg    <= ev_start_next;
            ev_end_reg      <= ev_end_next;
            ev_min_reg      <= ev_min_next;
            ev_max_reg      <= ev_max_next;
        end
    end

    // Two-entry result buffer: head plus skid
    logic [1:0]        count_reg, count_next;
    vssd_pkg::result_t head_reg, head_next;
    vssd_pkg::result_t skid_reg, skid_next;

    assign sample.ready   = (count_reg != 2'd2);
    assign result.valid   = (count_reg != 2'd0);
    assign result.payload = head_reg;

    always_comb
    begin
        count_next = count_reg;
        head_next  = head_reg;
        skid_next  = skid_reg;
        priority if (push && !pop)
        begin
            if (count_reg == 2'd0) head_next = res_next;
            else                   skid_next = res_next;
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            head_next  = skid_reg;
            count_next = count_reg - 2'd1;
        end
        else if (push && pop)
        begin
            if (count_reg == 2'd1)
            begin
                head_next = res_next;
            end
            else
            begin
                head_next = skid_reg;
                skid_next = res_next;
            end
        end
        else
        begin
            count_next = count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 2'd0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

    // Checks
    a_post_needs_active: assert property (@(posedge clk) disable iff (!rst_n)
        post_flag_reg |-> active_flag_reg)
        else $error("post phase without active event");

    a_start_done_excl: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !(res_next.event_started && res_next.event_done))
        else $error("event started and completed on one sample");

    a_done_clears_active: assert property (@(posedge clk) disable iff (!rst_n)
        (push && res_next.event_done) |=> !active_flag_reg && !post_flag_reg)
        else $error("event still active after completion");

    a_no_signal_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (push && s.no_signal) |=> !active_flag_reg && sag_run_reg == '0
                                  && swell_run_reg == '0)
        else $error("no-signal sample left event state");

    a_buffer_depth: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd2 && !result.ready) |=> count_reg == 2'd2)
        else $error("full result buffer lost an entry while stalled");

endmodule
